// ===== hdl/mn_divider_setting_solver_top_macros.svh =====
// Assertion macros shared by the M/N:D divider setting solver modules.
// Each macro assumes signals named clock and reset in the including scope.
`ifndef MN_DIVIDER_SETTING_SOLVER_TOP_MACROS_SVH
`define MN_DIVIDER_SETTING_SOLVER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MNDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MNDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mnds_pkg.sv =====
// Shared types and constants of the M/N:D divider setting solver.
// Used by the divider, datapath, controller and top level; depends on nothing.
package mnds_pkg;

   localparam int RATE_W    = 32;
   localparam int WORD_W    = 32;
   localparam int CNT_W     = 16;
   localparam int PROD_W    = RATE_W + CNT_W;
   localparam int CSR_IDX_W = 1;
   localparam int CODE_W    = 2;

   typedef logic [CODE_W-1:0] status_code_type;
   localparam status_code_type ST_OK         = 2'd0;
   localparam status_code_type ST_NO_COUNTER = 2'd1;
   localparam status_code_type ST_BAD_RATIO  = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_COUNTER_MASK   = 1'b0;
   localparam csr_index_type CSR_HAS_MN_COUNTER = 1'b1;

   localparam logic [CNT_W-1:0] MASK_RESET = 16'd255;

   // Fixed bit fields of the NS word.
   localparam logic [WORD_W-1:0] PREDIV_FIELD   = 32'h0000_0018;
   localparam logic [WORD_W-1:0] MODE_FIELD     = 32'h0000_0060;
   localparam logic [WORD_W-1:0] MODE_DUAL_EDGE = 32'h0000_0040;
   localparam logic [WORD_W-1:0] MN_COUNTER_EN  = 32'h0000_0100;
   localparam logic [WORD_W-1:0] ROOT_ENABLE    = 32'h0000_0800;

   typedef struct packed {
      logic            load;
      logic            halve;
      logic            mul;
      logic            div_start;
      logic            inc_n;
      logic            publish;
      status_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic has_mn;
      logic fout_zero;
      logic both_even;
      logic outside;
      logic m_zero;
      logic mismatch;
      logic div_busy;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== hdl/mnds_div.sv =====
// Serial restoring divider, one quotient bit per clock.
// Depends on mnds_pkg for the operand widths.
module mnds_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mnds_pkg::PROD_W-1:0]   dividend,
   input  logic [mnds_pkg::CNT_W-1:0]    divisor,
   output logic                          busy,
   output logic                          done,
   output logic [mnds_pkg::RATE_W-1:0]   quotient
);
   import mnds_pkg::*;

   localparam int STEP_W = $clog2(RATE_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // The quotient is known to fit RATE_W bits, so the upper dividend bits are
   // already a valid partial remainder below the divisor.
   assign trial = {rem_ff, quo_ff[RATE_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(RATE_W - 1);
         rem_in  = dividend[PROD_W-1:RATE_W];
         quo_in  = dividend[RATE_W-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[RATE_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/mnds_dp.sv =====
// Datapath of the divider setting solver: configuration, M/N registers,
// multiplier, serial divider and the result register. Depends on mnds_pkg and mnds_div.
`include "mn_divider_setting_solver_top_macros.svh"

module mnds_dp #(
   parameter int unsigned FIELD_SHIFT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  mnds_pkg::csr_index_type         csr_index,
   input  logic [mnds_pkg::CNT_W-1:0]      csr_wdata,
   input  logic [mnds_pkg::RATE_W-1:0]     req_input_rate,
   input  logic [mnds_pkg::RATE_W-1:0]     req_requested_rate,
   input  logic [mnds_pkg::WORD_W-1:0]     req_current_ns_word,
   input  logic [mnds_pkg::WORD_W-1:0]     req_current_md_word,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [mnds_pkg::WORD_W-1:0]     rsp_new_ns_word,
   output logic [mnds_pkg::WORD_W-1:0]     rsp_new_md_word,
   output logic [mnds_pkg::RATE_W-1:0]     rsp_achieved_rate,
   output logic [mnds_pkg::CNT_W-1:0]      rsp_m_value,
   output logic [mnds_pkg::CNT_W-1:0]      rsp_n_value,
   output mnds_pkg::status_code_type       rsp_status,
   input  mnds_pkg::dp_cmd_type            cmd,
   output mnds_pkg::dp_sts_type            sts
);
   import mnds_pkg::*;

   logic [CNT_W-1:0]  mask_ff;
   logic              has_mn_ff;
   logic [RATE_W-1:0] fin_ff, fout_ff;
   logic [WORD_W-1:0] ns_ff, md_ff;
   logic [RATE_W-1:0] m_ff, m_in;
   logic [RATE_W-1:0] n_ff, n_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [RATE_W-1:0] fout_clip;
   logic              div_busy, div_done;
   logic [RATE_W-1:0] div_quo;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] ns_out_ff, md_out_ff;
   logic [RATE_W-1:0] rate_out_ff;
   logic [CNT_W-1:0]  m_out_ff, n_out_ff;
   status_code_type   code_out_ff;

   logic [WORD_W-1:0] mask_word, field_hi, rn, ns_new, md_new;

   assign fout_clip = (req_requested_rate > req_input_rate) ? req_input_rate
                                                            : req_requested_rate;
   assign prod_in   = fin_ff * m_ff[CNT_W-1:0];

   always_comb begin
      m_in = m_ff;
      n_in = n_ff;
      if (cmd.load) begin
         m_in = fout_clip;
         n_in = req_input_rate;
      end else if (cmd.halve) begin
         m_in = m_ff >> 1;
         n_in = n_ff >> 1;
      end else if (cmd.inc_n) begin
         n_in = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= MASK_RESET;
         has_mn_ff <= 1'b1;
         m_ff      <= '0;
         n_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_COUNTER_MASK:   mask_ff   <= csr_wdata;
               CSR_HAS_MN_COUNTER: has_mn_ff <= csr_wdata[0];
            endcase
         end
         m_ff <= m_in;
         n_ff <= n_in;
      end
      if (cmd.load) begin
         fin_ff  <= req_input_rate;
         fout_ff <= fout_clip;
         ns_ff   <= req_current_ns_word;
         md_ff   <= req_current_md_word;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   mnds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (n_ff[CNT_W-1:0]),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Field packing of the new control words.
   assign mask_word = {{(WORD_W-CNT_W){1'b0}}, mask_ff};
   assign field_hi  = mask_word << FIELD_SHIFT;
   assign rn        = ~(n_ff - m_ff);
   assign ns_new    = (ns_ff & ~PREDIV_FIELD & ~field_hi & ~MODE_FIELD)
                    | ((rn & mask_word) << FIELD_SHIFT)
                    | MODE_DUAL_EDGE | MN_COUNTER_EN | ROOT_ENABLE;
   assign md_new    = (md_ff & ~field_hi & ~mask_word)
                    | ((m_ff & mask_word) << FIELD_SHIFT)
                    | (~n_ff & mask_word);

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.publish) begin
         code_out_ff <= cmd.code;
         if (cmd.code == ST_OK) begin
            ns_out_ff   <= ns_new;
            md_out_ff   <= md_new;
            rate_out_ff <= div_quo;
            m_out_ff    <= m_ff[CNT_W-1:0];
            n_out_ff    <= n_ff[CNT_W-1:0];
         end else begin
            ns_out_ff   <= ns_ff;
            md_out_ff   <= md_ff;
            rate_out_ff <= '0;
            m_out_ff    <= '0;
            n_out_ff    <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_ns_word   = ns_out_ff;
   assign rsp_new_md_word   = md_out_ff;
   assign rsp_achieved_rate = rate_out_ff;
   assign rsp_m_value       = m_out_ff;
   assign rsp_n_value       = n_out_ff;
   assign rsp_status        = code_out_ff;

   assign sts.has_mn    = has_mn_ff;
   assign sts.fout_zero = (fout_ff == '0);
   assign sts.both_even = ~m_ff[0] & ~n_ff[0];
   assign sts.outside   = (((m_ff | n_ff) & ~mask_word) != '0);
   assign sts.m_zero    = (m_ff == '0);
   assign sts.mismatch  = (div_quo != fout_ff);
   assign sts.div_busy  = div_busy;
   assign sts.div_done  = div_done;
   assign sts.out_free  = ~rsp_valid_ff | ~rsp_stall;

   `MNDS_ASSERT(a_m_not_above_n, m_ff <= n_ff, "M exceeds N")
   `MNDS_ASSERT_NEXT(a_publish_shows, cmd.publish, rsp_valid_ff, "published result not valid")
   `MNDS_ASSERT(a_div_operands, !cmd.div_start || ((n_ff[RATE_W-1:CNT_W] == '0) && (m_ff != '0)), "divider started with bad operands")

endmodule

// ===== hdl/mnds_ctrl.sv =====
// Controller state machine of the divider setting solver.
// Sequences the datapath by command and status structs from mnds_pkg.
`include "mn_divider_setting_solver_top_macros.svh"

module mnds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output mnds_pkg::dp_cmd_type  cmd,
   input  mnds_pkg::dp_sts_type  sts
);
   import mnds_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_EVEN    = 3'd2;
   localparam logic [2:0] S_FIT     = 3'd3;
   localparam logic [2:0] S_MUL     = 3'd4;
   localparam logic [2:0] S_DSTART  = 3'd5;
   localparam logic [2:0] S_DWAIT   = 3'd6;
   localparam logic [2:0] S_PUBLISH = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic            pass_ff, pass_in;
   status_code_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            pass_in = 1'b0;
            if (!sts.has_mn) begin
               code_in  = ST_NO_COUNTER;
               state_in = S_PUBLISH;
            end else if (sts.fout_zero) begin
               code_in  = ST_BAD_RATIO;
               state_in = S_PUBLISH;
            end else begin
               state_in = S_EVEN;
            end
         end
         S_EVEN: begin
            if (sts.both_even) begin
               cmd.halve = 1'b1;
            end else begin
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            priority if (sts.outside) begin
               cmd.halve = 1'b1;
            end else if (sts.m_zero) begin
               code_in  = ST_BAD_RATIO;
               state_in = S_PUBLISH;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               if (!pass_ff) begin
                  cmd.inc_n = sts.mismatch;
                  pass_in   = 1'b1;
                  state_in  = S_FIT;
               end else begin
                  code_in  = ST_OK;
                  state_in = S_PUBLISH;
               end
            end
         end
         S_PUBLISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `MNDS_ASSERT(a_publish_free, !cmd.publish || sts.out_free, "result register overwritten")
   `MNDS_ASSERT_NEXT(a_start_busy, cmd.div_start, sts.div_busy, "divider did not start")
   `MNDS_ASSERT(a_wait_div, (state_ff != S_DWAIT) || sts.div_busy || sts.div_done, "waiting on an idle divider")

endmodule

// ===== hdl/mn_divider_setting_solver_top.sv =====
// Top level of the M/N:D root clock divider setting solver.
// Depends on mnds_pkg, mnds_ctrl, mnds_dp and mnds_div.

// The block takes one transaction at a time: an input rate, a requested rate
// and the current NS and MD words, and returns one transaction with the new
// words, the chosen M and N, the achieved rate and a status code. The time a
// request takes from acceptance to a ready result grows with E + F1 + F2,
// where E is the number of common factors of two removed from M and N and F1
// and F2 are the right shifts of the two fit passes. Each halving takes one
// bit off N and the increment between the passes adds at most one, so
// E + F1 + F2 never exceeds 33. The time is set by the one-bit-per-cycle
// shift loops in the datapath and by the shared serial divider, which runs
// once for each of the two quotients of input rate times M over N. Error
// cases (no M/N counter, zero request or input rate, M shifted to zero)
// finish early. The result sits in an output register, so the block is ready
// for the next transaction as soon as the result is in that register, while
// that result may still wait on rsp_stall. Configuration
// writes (counter_mask at index 0, has_mn_counter at index 1) are taken at
// any edge with csr_write_en high and must only be made while the block is idle.
module mn_divider_setting_solver_top #(
   parameter int unsigned FIELD_SHIFT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  mnds_pkg::csr_index_type         csr_index,
   input  logic [mnds_pkg::CNT_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mnds_pkg::RATE_W-1:0]     req_input_rate,
   input  logic [mnds_pkg::RATE_W-1:0]     req_requested_rate,
   input  logic [mnds_pkg::WORD_W-1:0]     req_current_ns_word,
   input  logic [mnds_pkg::WORD_W-1:0]     req_current_md_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mnds_pkg::WORD_W-1:0]     rsp_new_ns_word,
   output logic [mnds_pkg::WORD_W-1:0]     rsp_new_md_word,
   output logic [mnds_pkg::RATE_W-1:0]     rsp_achieved_rate,
   output logic [mnds_pkg::CNT_W-1:0]      rsp_m_value,
   output logic [mnds_pkg::CNT_W-1:0]      rsp_n_value,
   output mnds_pkg::status_code_type       rsp_status
);
   import mnds_pkg::*;

   // Commands flow from the controller to the datapath; status flows back.
   dp_cmd_type cmd;
   dp_sts_type sts;

   mnds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the configuration registers, the working M and N,
   // the multiplier and divider, and the result register.
   mnds_dp #(
      .FIELD_SHIFT (FIELD_SHIFT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_input_rate      (req_input_rate),
      .req_requested_rate  (req_requested_rate),
      .req_current_ns_word (req_current_ns_word),
      .req_current_md_word (req_current_md_word),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_new_ns_word     (rsp_new_ns_word),
      .rsp_new_md_word     (rsp_new_md_word),
      .rsp_achieved_rate   (rsp_achieved_rate),
      .rsp_m_value         (rsp_m_value),
      .rsp_n_value         (rsp_n_value),
      .rsp_status          (rsp_status),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

// ===== sim/mn_divider_setting_solver_top_test.sv =====
// Self-checking testbench for the M/N:D root clock divider setting solver.
// Depends on mnds_pkg and mn_divider_setting_solver_top; predicts every result
// itself and compares each one field by field.
module mn_divider_setting_solver_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mnds_pkg::*;

   localparam int unsigned SETTING_FIELD_SHIFT = 16;
   // Watchdog limit on the length of the whole run.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Extra wait at the end, longer than the slowest request takes.
   localparam int DRAIN_CYCLES = 300;
   // Long enough for the block to fill its output register and its datapath.
   localparam int HOLD_OFF_CYCLES = 800;
   localparam int MAX_REPORTED = 10;

   // One result transaction as the block should present it.
   typedef struct packed {
      logic [WORD_W-1:0] ns_word;
      logic [WORD_W-1:0] md_word;
      logic [RATE_W-1:0] achieved;
      logic [CNT_W-1:0]  m;
      logic [CNT_W-1:0]  n;
      status_code_type   status;
   } divider_setting_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index = CSR_COUNTER_MASK;
   logic [CNT_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [RATE_W-1:0]   req_input_rate = '0;
   logic [RATE_W-1:0]   req_requested_rate = '0;
   logic [WORD_W-1:0]   req_current_ns_word = '0;
   logic [WORD_W-1:0]   req_current_md_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_new_ns_word;
   logic [WORD_W-1:0]   rsp_new_md_word;
   logic [RATE_W-1:0]   rsp_achieved_rate;
   logic [CNT_W-1:0]    rsp_m_value;
   logic [CNT_W-1:0]    rsp_n_value;
   status_code_type     rsp_status;

   // Our own copy of the two registers, kept in step with every write.
   logic [CNT_W-1:0]    mask_setting = MASK_RESET;
   logic                has_mn_setting = 1'b1;

   // Settings still owed by the block, oldest first.
   divider_setting_type expected_settings[$];
   divider_setting_type want;
   int                  fail_count = 0;
   int                  results_seen = 0;
   int                  cycle_count = 0;

   // Receiver hold-off bookkeeping: the test bumps the request count, the
   // stall process serves each request by counting cycles on its own.
   int                  hold_requests = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  stall_mode = 0;
   int                  stall_phase_left = 0;

   mn_divider_setting_solver_top #(
      .FIELD_SHIFT(SETTING_FIELD_SHIFT)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_input_rate      (req_input_rate),
      .req_requested_rate  (req_requested_rate),
      .req_current_ns_word (req_current_ns_word),
      .req_current_md_word (req_current_md_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_new_ns_word     (rsp_new_ns_word),
      .rsp_new_md_word     (rsp_new_md_word),
      .rsp_achieved_rate   (rsp_achieved_rate),
      .rsp_m_value         (rsp_m_value),
      .rsp_n_value         (rsp_n_value),
      .rsp_status          (rsp_status)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Halve M and N together until neither has a bit outside the counter mask.
   // Halving always reaches zero, so this ends for any mask value.
   function automatic void fit_counter_width(inout logic [31:0] m, inout logic [31:0] n);
      logic [31:0] outside;
      outside = ~{16'b0, mask_setting};
      while (((m & outside) != 0) || ((n & outside) != 0)) begin
         m = m >> 1;
         n = n >> 1;
      end
   endfunction

   // Works out the control words and the achieved rate for one request under
   // the current register settings. M never exceeds N, because the request is
   // clipped to the input rate and halving keeps that order, so N is never 0
   // when it is used as a divisor.
   function automatic divider_setting_type solve_divider_setting(
      input logic [31:0] fin, input logic [31:0] fout_in,
      input logic [31:0] ns_in, input logic [31:0] md_in);
      divider_setting_type s;
      logic [31:0] fout, m, n, msk, hi_field, not_diff, not_n;
      logic [63:0] product;
      s.ns_word  = ns_in;
      s.md_word  = md_in;
      s.achieved = '0;
      s.m        = '0;
      s.n        = '0;
      s.status   = ST_OK;
      if (!has_mn_setting) begin
         s.status = ST_NO_COUNTER;
         return s;
      end
      fout = (fout_in > fin) ? fin : fout_in;
      if (fout == 0) begin
         s.status = ST_BAD_RATIO;
         return s;
      end
      m = fout;
      n = fin;
      // Strip common factors of two; M is nonzero, so this ends.
      while (!m[0] && !n[0]) begin
         m = m >> 1;
         n = n >> 1;
      end
      fit_counter_width(m, n);
      if (m == 0) begin
         s.status = ST_BAD_RATIO;
         return s;
      end
      product = {32'b0, fin} * {32'b0, m};
      // An inexact ratio rounds N up by one, which may push it past the mask.
      if (product / {32'b0, n} != {32'b0, fout})
         n = n + 1;
      fit_counter_width(m, n);
      if (m == 0) begin
         s.status = ST_BAD_RATIO;
         return s;
      end
      msk      = {16'b0, mask_setting};
      hi_field = msk << SETTING_FIELD_SHIFT;
      not_diff = ~(n - m);
      not_n    = ~n;
      s.ns_word = ns_in & ~PREDIV_FIELD & ~hi_field & ~MODE_FIELD;
      s.ns_word = s.ns_word | ((not_diff & msk) << SETTING_FIELD_SHIFT);
      s.ns_word = s.ns_word | MODE_DUAL_EDGE | MN_COUNTER_EN | ROOT_ENABLE;
      s.md_word = md_in & ~hi_field & ~msk;
      s.md_word = s.md_word | ((m & msk) << SETTING_FIELD_SHIFT) | (not_n & msk);
      product   = {32'b0, fin} * {32'b0, m};
      s.achieved = 32'(product / {32'b0, n});
      s.m = m[15:0];
      s.n = n[15:0];
      return s;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTED)
         $display("%s", what);
   endtask

   // Offers one request transaction and returns at the edge that accepts it.
   // Valid is left high so a following call can keep the channel busy; the
   // caller lowers it when a gap starts.
   task automatic offer_rate_request(input logic [31:0] fin, input logic [31:0] fout,
                                     input logic [31:0] ns, input logic [31:0] md);
      req_valid           <= 1'b1;
      req_input_rate      <= fin;
      req_requested_rate  <= fout;
      req_current_ns_word <= ns;
      req_current_md_word <= md;
      do @(posedge clock); while (req_stall);
      expected_settings.push_back(solve_divider_setting(fin, fout, ns, md));
   endtask

   // Picks a request. Most are well formed (request at or below the input rate,
   // both nonzero, often with exact ratios or shared factors of two) so that
   // the search runs all the way through; the rest are raw noise and edges.
   task automatic offer_random_request();
      logic [31:0] fin, fout;
      int unsigned a, b;
      case ($urandom_range(9, 0))
         0: begin
            fin  = $urandom;
            fout = $urandom;
         end
         1: begin
            fin  = $urandom_range(600, 1);
            fout = $urandom_range(700, 0);
         end
         2: begin
            fin  = $urandom_range(4000, 1) << $urandom_range(20, 0);
            fout = fin >> $urandom_range(12, 0);
         end
         3: begin
            fin  = $urandom_range(100, 1) * 32'd1_000_000;
            fout = $urandom_range(fin, 1);
         end
         4: begin
            case ($urandom_range(3, 0))
               0: fin = '0;
               1: fin = 32'd1;
               2: fin = '1;
               default: fin = $urandom;
            endcase
            case ($urandom_range(3, 0))
               0: fout = '0;
               1: fout = 32'd1;
               2: fout = '1;
               default: fout = fin;
            endcase
         end
         5: begin
            fin  = $urandom;
            fout = $urandom_range(fin, 0);
         end
         default: begin
            fin  = $urandom;
            b    = $urandom_range(300, 2);
            a    = $urandom_range(b, 1);
            fout = (fin / b) * a;
         end
      endcase
      offer_rate_request(fin, fout, $urandom, $urandom);
   endtask

   // Sends random requests in bursts with random gaps between them. A gap of
   // zero keeps valid high across bursts; valid is only lowered when a real
   // gap starts or the run of requests ends.
   task automatic offer_random_burst_run(input int count);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(12, 1);
         for (int i = 0; i < burst && sent < count; i++) begin
            offer_random_request();
            sent++;
         end
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Writes both registers while the block is idle. Every request causes
   // exactly one result, so an empty expectation queue means nothing is in
   // flight any more.
   task automatic write_divider_settings(input logic [CNT_W-1:0] mask, input logic has_mn);
      while (expected_settings.size() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_COUNTER_MASK;
      csr_wdata    <= mask;
      @(posedge clock);
      csr_index    <= CSR_HAS_MN_COUNTER;
      csr_wdata    <= {{(CNT_W-1){1'b0}}, has_mn};
      @(posedge clock);
      csr_write_en <= 1'b0;
      mask_setting   = mask;
      has_mn_setting = has_mn;
   endtask

   // Directed requests under the reset settings (mask 255, counter present):
   // zero rates, clipping, max values, exact and inexact ratios, and both
   // places where M can be shifted down to zero.
   task automatic test_directed_rates();
      offer_rate_request(32'd0, 32'd0, 32'd0, 32'd0);
      offer_rate_request(32'd100_000_000, 32'd0, '1, '1);
      offer_rate_request(32'd0, 32'd12345, 32'hAAAA_5555, 32'h5555_AAAA);
      offer_rate_request('1, '1, 32'd0, '1);
      // M falls to zero in the first fit.
      offer_rate_request('1, 32'd1, 32'h1234_5678, 32'h9ABC_DEF0);
      // Request above the input rate is clipped.
      offer_rate_request(32'd1000, 32'd2000, '1, 32'd0);
      offer_rate_request(32'd48_000_000, 32'd12_000_000, $urandom, $urandom);
      offer_rate_request(32'd19_200_000, 32'd7_000_000, $urandom, $urandom);
      // Inexact ratio: N is bumped past the mask and the second fit runs.
      offer_rate_request(32'd65535, 32'd1000, $urandom, $urandom);
      // Same path, but the second fit shifts M down to zero.
      offer_rate_request(32'd65535, 32'd300, $urandom, $urandom);
      offer_rate_request(32'd1, 32'd1, $urandom, $urandom);
      offer_rate_request(32'd27_000_000, 32'd25_175_000, $urandom, $urandom);
      offer_rate_request(32'h8000_0000, 32'h4000_0000, $urandom, $urandom);
      offer_rate_request(32'd200, 32'd199, $urandom, $urandom);
      req_valid <= 1'b0;
   endtask

   // The register extremes: widest and narrowest mask, a mask that is not a
   // power of two minus one, and a clock without an M/N counter.
   task automatic test_register_extremes();
      write_divider_settings(16'hFFFF, 1'b1);
      offer_rate_request('1, 32'hFFFF_FFFE, $urandom, $urandom);
      offer_rate_request('1, 32'h1234_5678, '1, '1);
      req_valid <= 1'b0;
      write_divider_settings(16'h0001, 1'b1);
      offer_rate_request(32'd3, 32'd1, $urandom, $urandom);
      offer_rate_request(32'd10, 32'd5, $urandom, $urandom);
      req_valid <= 1'b0;
      write_divider_settings(16'h5A5A, 1'b1);
      offer_rate_request(32'd48_000_000, 32'd12_000_000, $urandom, $urandom);
      offer_rate_request(32'd700, 32'd350, $urandom, $urandom);
      req_valid <= 1'b0;
      write_divider_settings(MASK_RESET, 1'b0);
      offer_rate_request(32'd100, 32'd50, $urandom, $urandom);
      req_valid <= 1'b0;
   endtask

   // The receiver holds off for a long stretch while requests keep coming
   // back to back, so the output register fills and the block must stall
   // its input until the receiver drains it.
   task automatic test_output_hold_off();
      write_divider_settings(16'hFFFF, 1'b1);
      hold_requests++;
      for (int i = 0; i < 12; i++)
         offer_random_request();
      req_valid <= 1'b0;
   endtask

   // Random requests across a series of register settings, extremes first.
   task automatic test_random_settings();
      logic [CNT_W-1:0] mask;
      logic             has_mn;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: mask = 16'h0001;
            1: mask = 16'hFFFF;
            2: mask = MASK_RESET;
            3: mask = 16'h5A5A;
            default: begin
               if ($urandom_range(1, 0) == 0)
                  mask = CNT_W'((32'd1 << $urandom_range(16, 1)) - 1);
               else
                  mask = CNT_W'($urandom_range(65535, 1));
            end
         endcase
         has_mn = (phase == 2) ? 1'b0 : ($urandom_range(7, 0) != 0);
         write_divider_settings(mask, has_mn);
         offer_random_burst_run(65);
      end
   endtask

   // Receiver side: a stall pattern that changes character every so often
   // (never, light, half, heavy), with a long hold-off served on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_OFF_CYCLES;
      end else begin
         if (stall_phase_left == 0) begin
            stall_mode       <= $urandom_range(3, 0);
            stall_phase_left <= $urandom_range(200, 20);
         end else begin
            stall_phase_left <= stall_phase_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            2: rsp_stall <= ($urandom_range(1, 0) == 0);
            default: rsp_stall <= ($urandom_range(3, 0) != 0);
         endcase
      end
   end

   // Every accepted result transaction is checked against the oldest
   // expectation. Sampling happens right at the edge, before any of this
   // edge's updates, so the values seen are those the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_settings.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected: ns %h md %h",
                                   results_seen, rsp_new_ns_word, rsp_new_md_word));
         end else begin
            want = expected_settings.pop_front();
            if (rsp_new_ns_word !== want.ns_word || rsp_new_md_word !== want.md_word ||
                rsp_achieved_rate !== want.achieved || rsp_m_value !== want.m ||
                rsp_n_value !== want.n || rsp_status !== want.status)
               note_failure($sformatf(
                  {"result %0d mismatch: expected ns %h md %h rate %0d m %0d n %0d st %0d,",
                   " got ns %h md %h rate %0d m %0d n %0d st %0d"},
                  results_seen, want.ns_word, want.md_word, want.achieved, want.m,
                  want.n, want.status, rsp_new_ns_word, rsp_new_md_word,
                  rsp_achieved_rate, rsp_m_value, rsp_n_value, rsp_status));
         end
         results_seen++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_rates();
      test_register_extremes();
      test_output_hold_off();
      test_random_settings();
      // Wait out every result, then a while longer so a stray extra result
      // would still be caught by the checker.
      while (expected_settings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_settings.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mnds_pkg.sv
hdl/mnds_div.sv
hdl/mnds_dp.sv
hdl/mnds_ctrl.sv
hdl/mn_divider_setting_solver_top.sv
sim/mn_divider_setting_solver_top_test.sv
